// File: sv/mbsp_pkg.sv
// Shared types, constants and helper functions for the MIDI byte stream parser.
// No dependencies; mbsp_front, mbsp_back and the top level import this package.
package mbsp_pkg;

  // Default queue depths; both must be powers of two, the result queue at least two.
  localparam int TOK_DEPTH_DEF = 4;
  localparam int RES_DEPTH_DEF = 4;

  // Result kinds.
  localparam logic [3:0] KIND_NOTEOFF    = 4'd0;
  localparam logic [3:0] KIND_NOTEON     = 4'd1;
  localparam logic [3:0] KIND_MTC        = 4'd7;
  localparam logic [3:0] KIND_SONGPOS    = 4'd8;
  localparam logic [3:0] KIND_SONGSEL    = 4'd9;
  localparam logic [3:0] KIND_TUNE       = 4'd10;
  localparam logic [3:0] KIND_REALTIME   = 4'd11;
  localparam logic [3:0] KIND_SYSEXBYTE  = 4'd12;
  localparam logic [3:0] KIND_INVALID    = 4'd13;
  localparam logic [3:0] KIND_UNEXPECTED = 4'd14;

  // Status bytes with a special meaning.
  localparam logic [7:0] ST_NONE      = 8'h00;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_MTC       = 8'hF1;
  localparam logic [7:0] ST_SONGPOS   = 8'hF2;
  localparam logic [7:0] ST_SONGSEL   = 8'hF3;
  localparam logic [7:0] ST_UNDEF_F4  = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5  = 8'hF5;
  localparam logic [7:0] ST_TUNE      = 8'hF6;
  localparam logic [7:0] ST_EOX       = 8'hF7;
  localparam logic [7:0] ST_RT_BASE   = 8'hF8;
  localparam logic [7:0] ST_UNDEF_F9  = 8'hF9;
  localparam logic [7:0] ST_UNDEF_FD  = 8'hFD;
  localparam logic [7:0] ST_SYS_BASE  = 8'hF0;

  localparam logic [6:0] VEL_NOTEOFF  = 7'h40;

  // Coarse byte class decided by the front end.
  typedef enum logic [1:0] {
    CLS_DATA   = 2'd0,
    CLS_STATUS = 2'd1,
    CLS_RT     = 2'd2,
    CLS_RT_BAD = 2'd3
  } tok_cls_t;

  typedef struct packed {
    tok_cls_t   cls;
    logic [7:0] data;
  } tok_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] channel;
    logic [7:0] first_data;
    logic [6:0] second_data;
    logic       last;
  } res_t;

  // Up to two result words written to the result queue in one cycle.
  typedef struct packed {
    logic push0;
    logic push1;
    res_t res0;
    res_t res1;
  } res_wr_t;

  // True when the status takes two data bytes.
  function automatic logic two_data(input logic [7:0] s);
    logic r;
    r = 1'b1;
    case (s[7:4])
      4'hC, 4'hD: r = 1'b0;
      4'hF:       r = (s == ST_SONGPOS);
      default:    r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// File: sv/mbsp_fifo.sv
// Small register queue with two write lanes and one read port.
// Depends on nothing; used for the token queue and the result queue.
module mbsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push0,
  input  logic             push1,
  input  logic [WIDTH-1:0] wdata0,
  input  logic [WIDTH-1:0] wdata1,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full,
  output logic             room2
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    free;
  logic             do_pop;

  assign free   = CW'(DEPTH) - count;
  assign empty  = (count == '0);
  assign full   = (free == '0);
  assign room2  = (free >= CW'(2));
  assign do_pop = pop && !empty;
  assign rdata  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= wdata0;
    end
    if (push1) begin
      mem[wr_ptr + AW'(1)] <= wdata1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push0) + AW'(push1);
      rd_ptr <= rd_ptr + AW'(do_pop);
      count  <= count + CW'(push0) + CW'(push1) - CW'(do_pop);
    end
  end

endmodule

// File: sv/mbsp_front.sv
// Front end: classifies each received byte and writes it to the token queue.
// Depends on mbsp_pkg and mbsp_fifo.
module mbsp_front import mbsp_pkg::*; #(
  parameter int TOK_DEPTH = TOK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       push,
  output logic       full,
  input  logic       tok_pop,
  output tok_t       tok,
  output logic       tok_empty
);

  tok_t             cls_tok;
  logic             wr;
  logic [$bits(tok_t)-1:0] rd_bits;

  always_comb begin
    cls_tok.data = rx_byte;
    if (rx_byte >= ST_RT_BASE) begin
      cls_tok.cls = (rx_byte == ST_UNDEF_F9 || rx_byte == ST_UNDEF_FD) ? CLS_RT_BAD : CLS_RT;
    end else if (rx_byte[7]) begin
      cls_tok.cls = CLS_STATUS;
    end else begin
      cls_tok.cls = CLS_DATA;
    end
  end

  assign wr  = push && !full;
  assign tok = tok_t'(rd_bits);

  mbsp_fifo #(
    .WIDTH($bits(tok_t)),
    .DEPTH(TOK_DEPTH)
  ) u_tok_q (
    .clk   (clk),
    .rst   (rst),
    .push0 (wr),
    .push1 (1'b0),
    .wdata0(cls_tok),
    .wdata1(cls_tok),
    .pop   (tok_pop),
    .rdata (rd_bits),
    .empty (tok_empty),
    .full  (full),
    .room2 ()
  );

endmodule

// File: sv/mbsp_back.sv
// Back end: keeps the running status and message assembly state and turns
// each classified byte into zero, one or two result words. Depends on mbsp_pkg.
module mbsp_back import mbsp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  tok_t    tok,
  input  logic    tok_empty,
  output logic    tok_pop,
  input  logic    res_room2,
  output res_wr_t wr
);

  logic [7:0] run_status, run_status_next;
  logic [7:0] current_status, current_status_next;
  logic       data_count, data_count_next;
  logic [6:0] held_data, held_data_next;
  logic       sysex_active, sysex_active_next;

  assign tok_pop = !tok_empty && res_room2;

  always_comb begin
    res_t       fresh;
    logic       fresh_v;
    logic       inter;
    logic       done;
    logic [7:0] b;
    logic [7:0] cur_eff;
    logic       two;
    logic [3:0] k;
    logic [7:0] d1;
    logic [6:0] d2;

    run_status_next     = run_status;
    current_status_next = current_status;
    data_count_next     = data_count;
    held_data_next      = held_data;
    sysex_active_next   = sysex_active;
    wr                  = '0;
    fresh               = '0;
    fresh_v             = 1'b0;
    inter               = 1'b0;
    done                = 1'b0;
    b                   = tok.data;
    cur_eff             = current_status;
    two                 = 1'b0;
    k                   = '0;
    d1                  = '0;
    d2                  = '0;

    if (tok_pop) begin
      case (tok.cls)
        CLS_RT_BAD: begin
          wr.push0            = 1'b1;
          wr.res0.kind        = KIND_INVALID;
          wr.res0.first_data  = b;
          run_status_next     = ST_NONE;
          current_status_next = ST_NONE;
          data_count_next     = 1'b0;
          held_data_next      = '0;
          sysex_active_next   = 1'b0;
        end
        CLS_RT: begin
          wr.push0           = 1'b1;
          wr.res0.kind       = KIND_REALTIME;
          wr.res0.first_data = {5'b0, b[2:0]};
        end
        CLS_STATUS: begin
          // An open sysex run is cut short by any status but EOX; an open message by any status.
          if (sysex_active) begin
            sysex_active_next = 1'b0;
            if (b == ST_EOX) begin
              wr.push0           = 1'b1;
              wr.res0.kind       = KIND_SYSEXBYTE;
              wr.res0.first_data = ST_EOX;
              wr.res0.last       = 1'b1;
              run_status_next    = ST_NONE;
              done               = 1'b1;
            end else begin
              inter = 1'b1;
            end
          end else if (current_status != ST_NONE) begin
            inter               = 1'b1;
            current_status_next = ST_NONE;
            data_count_next     = 1'b0;
            held_data_next      = '0;
          end else if (b == ST_EOX && run_status == ST_NONE) begin
            done = 1'b1;
          end

          if (inter) begin
            wr.push0           = 1'b1;
            wr.res0.kind       = KIND_UNEXPECTED;
            wr.res0.first_data = b;
          end

          if (!done) begin
            if (b == ST_UNDEF_F4 || b == ST_UNDEF_F5 || b == ST_EOX) begin
              fresh_v             = 1'b1;
              fresh.kind          = KIND_INVALID;
              fresh.first_data    = b;
              run_status_next     = ST_NONE;
              current_status_next = ST_NONE;
              data_count_next     = 1'b0;
              held_data_next      = '0;
              sysex_active_next   = 1'b0;
            end else if (b == ST_SYSEX) begin
              fresh_v           = 1'b1;
              fresh.kind        = KIND_SYSEXBYTE;
              fresh.first_data  = ST_SYSEX;
              sysex_active_next = 1'b1;
              run_status_next   = ST_NONE;
            end else if (b == ST_TUNE) begin
              fresh_v         = 1'b1;
              fresh.kind      = KIND_TUNE;
              run_status_next = ST_NONE;
            end else begin
              current_status_next = b;
              data_count_next     = 1'b0;
              held_data_next      = '0;
            end
          end

          // The fresh result follows the unexpected-status word when there is one.
          if (fresh_v) begin
            if (inter) begin
              wr.push1 = 1'b1;
              wr.res1  = fresh;
            end else begin
              wr.push0 = 1'b1;
              wr.res0  = fresh;
            end
          end
        end
        default: begin
          if (sysex_active) begin
            wr.push0           = 1'b1;
            wr.res0.kind       = KIND_SYSEXBYTE;
            wr.res0.first_data = b;
          end else if (current_status != ST_NONE || run_status != ST_NONE) begin
            if (current_status == ST_NONE) begin
              cur_eff = run_status;
            end
            two = two_data(cur_eff);
            if (two && (current_status == ST_NONE || !data_count)) begin
              current_status_next = cur_eff;
              held_data_next      = b[6:0];
              data_count_next     = 1'b1;
            end else begin
              d1 = two ? {1'b0, held_data} : b;
              d2 = two ? b[6:0] : 7'd0;
              if (cur_eff >= ST_SYS_BASE) begin
                k = (cur_eff == ST_MTC) ? KIND_MTC :
                    (cur_eff == ST_SONGPOS) ? KIND_SONGPOS : KIND_SONGSEL;
                run_status_next = ST_NONE;
                wr.res0.channel = '0;
              end else begin
                k = {1'b0, cur_eff[6:4]};
                if (k == KIND_NOTEON && d2 == 7'd0) begin
                  k  = KIND_NOTEOFF;
                  d2 = VEL_NOTEOFF;
                end
                run_status_next = cur_eff;
                wr.res0.channel = cur_eff[3:0];
              end
              wr.push0            = 1'b1;
              wr.res0.kind        = k;
              wr.res0.first_data  = d1;
              wr.res0.second_data = d2;
              current_status_next = ST_NONE;
              data_count_next     = 1'b0;
              held_data_next      = '0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_status     <= ST_NONE;
      current_status <= ST_NONE;
      data_count     <= 1'b0;
      held_data      <= '0;
      sysex_active   <= 1'b0;
    end else begin
      run_status     <= run_status_next;
      current_status <= current_status_next;
      data_count     <= data_count_next;
      held_data      <= held_data_next;
      sysex_active   <= sysex_active_next;
    end
  end

endmodule

// File: sv/midi_byte_stream_parser.sv
// MIDI byte stream parser, top level: front end, token queue, back end, result queue.
// Each byte is registered in the token queue and its result words in the result queue.
// Throughput: one byte per cycle while results drain; a byte giving two words needs
// two pops. The back end runs a byte only when the result queue has two free slots.
// Reset (rst, synchronous) empties both queues and clears all parser state.
// Depends on mbsp_pkg, mbsp_fifo, mbsp_front and mbsp_back.
module midi_byte_stream_parser import mbsp_pkg::*; #(
  parameter int TOK_DEPTH = TOK_DEPTH_DEF,
  parameter int RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       push,
  output logic       full,
  output logic [3:0] kind,
  output logic [3:0] channel,
  output logic [7:0] first_data,
  output logic [6:0] second_data,
  output logic       last,
  output logic       empty,
  input  logic       pop
);

  // Classified bytes wait in the token queue, so the front end keeps taking
  // input while the back end is held up by a full result queue.
  tok_t    tok;
  logic    tok_empty;
  logic    tok_pop;
  logic    res_room2;
  res_wr_t res_wr;
  res_t    head;
  logic [$bits(res_t)-1:0] head_bits;

  mbsp_front #(
    .TOK_DEPTH(TOK_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (rx_byte),
    .push     (push),
    .full     (full),
    .tok_pop  (tok_pop),
    .tok      (tok),
    .tok_empty(tok_empty)
  );

  // The back end holds the running status and emits up to two words per byte:
  // an unexpected-status word first, then the word for the new status.
  mbsp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .tok      (tok),
    .tok_empty(tok_empty),
    .tok_pop  (tok_pop),
    .res_room2(res_room2),
    .wr       (res_wr)
  );

  // The result queue separates the back end from the consumer; its head
  // drives the result ports directly.
  mbsp_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push0 (res_wr.push0),
    .push1 (res_wr.push1),
    .wdata0(res_wr.res0),
    .wdata1(res_wr.res1),
    .pop   (pop),
    .rdata (head_bits),
    .empty (empty),
    .full  (),
    .room2 (res_room2)
  );

  assign head        = res_t'(head_bits);
  assign kind        = head.kind;
  assign channel     = head.channel;
  assign first_data  = head.first_data;
  assign second_data = head.second_data;
  assign last        = head.last;

endmodule
